@@ src/srca_pkg.sv @@
// shared types and constants for the sprite rectangle clip address block
package srca_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CLIP_TOP    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CLIP_RIGHT  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CLIP_BOTTOM = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SRC_WIDTH   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SRC_HEIGHT  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_SRC_STRIDE  = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_SRC_OFFSET  = 3'd7;

    // reset values
    localparam logic [6:0] RST_CLIP_RIGHT  = 7'd80;
    localparam logic [8:0] RST_CLIP_BOTTOM = 9'd400;

    typedef struct packed {
        logic [6:0]  clip_left;
        logic [8:0]  clip_top;
        logic [6:0]  clip_right;
        logic [8:0]  clip_bottom;
        logic [6:0]  src_width;
        logic [8:0]  src_height;
        logic [15:0] src_stride;
        logic [15:0] src_offset;
    } t_cfg;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        no_clip;
    } t_item;

    typedef struct packed {
        logic        visible;
        logic [15:0] vram_offset;
        logic [15:0] source_start;
        logic [8:0]  rows_out;
        logic [6:0]  bytes_out;
    } t_result;

endpackage

@@ src/srca_cfg_regs.sv @@
// configuration register file for the clip rectangle and sprite geometry
module srca_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [srca_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [srca_pkg::CfgDataW-1:0]      i_cfg_data,
    output srca_pkg::t_cfg                     o_cfg
);
    import srca_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_left   <= '0;
            r_cfg.clip_top    <= '0;
            r_cfg.clip_right  <= RST_CLIP_RIGHT;
            r_cfg.clip_bottom <= RST_CLIP_BOTTOM;
            r_cfg.src_width   <= '0;
            r_cfg.src_height  <= '0;
            r_cfg.src_stride  <= '0;
            r_cfg.src_offset  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CLIP_LEFT:   r_cfg.clip_left   <= i_cfg_data[6:0];
                REG_CLIP_TOP:    r_cfg.clip_top    <= i_cfg_data[8:0];
                REG_CLIP_RIGHT:  r_cfg.clip_right  <= i_cfg_data[6:0];
                REG_CLIP_BOTTOM: r_cfg.clip_bottom <= i_cfg_data[8:0];
                REG_SRC_WIDTH:   r_cfg.src_width   <= i_cfg_data[6:0];
                REG_SRC_HEIGHT:  r_cfg.src_height  <= i_cfg_data[8:0];
                REG_SRC_STRIDE:  r_cfg.src_stride  <= i_cfg_data;
                REG_SRC_OFFSET:  r_cfg.src_offset  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/srca_clip.sv @@
// clipping and address arithmetic for one sprite word
module srca_clip #(
    parameter int unsigned ROW_BYTES = 80
) (
    input  srca_pkg::t_cfg    i_cfg,
    input  srca_pkg::t_item   i_item,
    output srca_pkg::t_result o_res
);
    import srca_pkg::*;

    localparam logic [15:0] RowBytesW = 16'(ROW_BYTES);

    logic [15:0] x, y, cl, ct, cr, cb, sw, sh;
    logic        nc;
    logic        y_above, x_left;
    logic [15:0] dy, dx, ry, rx;
    logic [15:0] rows_top, bytes_left;
    logic [15:0] rows_v, bytes_v;
    logic        inv_v, inv_h;
    logic [15:0] skip_prod;
    logic [15:0] so_v, so_h;
    logic [15:0] row_sel, col_sel;
    logic [15:0] row_prod;
    logic [15:0] vo;
    logic        vis;

    assign x  = i_item.pos_x;
    assign y  = i_item.pos_y;
    assign nc = i_item.no_clip;
    assign cl = {9'd0, i_cfg.clip_left};
    assign ct = {7'd0, i_cfg.clip_top};
    assign cr = {9'd0, i_cfg.clip_right};
    assign cb = {7'd0, i_cfg.clip_bottom};
    assign sw = {9'd0, i_cfg.src_width};
    assign sh = {7'd0, i_cfg.src_height};

    // vertical edge: top only when above, else bottom only
    assign y_above  = $signed(y) < $signed(ct);
    assign dy       = y - ct;
    assign rows_top = sh + dy;
    assign ry       = cb - y;
    // only the low 16 bits of the skipped-row product are kept
    assign skip_prod = (16'd0 - dy) * i_cfg.src_stride;

    always_comb begin
        if (y_above) begin
            inv_v  = $signed(rows_top) <= 16'sd0;
            rows_v = rows_top;
            so_v   = i_cfg.src_offset + skip_prod;
        end else if ($signed(ry) < $signed(sh)) begin
            inv_v  = $signed(ry) <= 16'sd0;
            rows_v = ry;
            so_v   = i_cfg.src_offset;
        end else begin
            inv_v  = 1'b0;
            rows_v = sh;
            so_v   = i_cfg.src_offset;
        end
    end

    // horizontal edge, same ordering
    assign x_left     = $signed(x) < $signed(cl);
    assign dx         = x - cl;
    assign bytes_left = sw + dx;
    assign rx         = cr - x;

    always_comb begin
        if (x_left) begin
            inv_h   = $signed(bytes_left) <= 16'sd0;
            bytes_v = bytes_left;
            so_h    = so_v - dx;
        end else if ($signed(rx) < $signed(sw)) begin
            inv_h   = $signed(rx) <= 16'sd0;
            bytes_v = rx;
            so_h    = so_v;
        end else begin
            inv_h   = 1'b0;
            bytes_v = sw;
            so_h    = so_v;
        end
    end

    assign row_sel  = (!nc && y_above) ? ct : y;
    assign col_sel  = (!nc && x_left) ? cl : x;
    assign row_prod = row_sel * RowBytesW;
    assign vo       = row_prod + col_sel;
    assign vis      = nc || !(inv_v || inv_h);

    always_comb begin
        o_res = '0;
        if (nc) begin
            o_res.visible      = 1'b1;
            o_res.vram_offset  = vo;
            o_res.source_start = i_cfg.src_offset;
            o_res.rows_out     = i_cfg.src_height;
            o_res.bytes_out    = i_cfg.src_width;
        end else if (vis) begin
            o_res.visible      = 1'b1;
            o_res.vram_offset  = vo;
            o_res.source_start = so_h;
            o_res.rows_out     = rows_v[8:0];
            o_res.bytes_out    = bytes_v[6:0];
        end
    end

endmodule

@@ src/sprite_rect_clip_address.sv @@
// top level of the sprite rectangle clip and vram address setup block
// flow: a word accepted into the input register passes through the clip logic into the result
// register, which drives o_m_tvalid, and the word leaves when the sink raises i_m_tready
// throughput: one word per cycle while the sink keeps i_m_tready high, set by the single clip
// stage between the input register and the result register
// reset: synchronous, active low; empties both stages and loads the clip window
// to the full 80 by 400 screen with all sprite geometry zero
module sprite_rect_clip_address #(
    parameter int unsigned ROW_BYTES = 80
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [31:0]                   i_s_tdata,   // pos_x [15:0], pos_y [31:16]
    input  logic                          i_s_tuser,   // no_clip
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // vram_offset [15:0], source_start [31:16], rows_out [40:32], bytes_out [47:41]
    output logic [47:0]                   o_m_tdata,
    output logic                          o_m_tuser,   // visible
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [srca_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [srca_pkg::CfgDataW-1:0] i_cfg_data
);
    import srca_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    t_result clip_res;
    t_result r_res;
    logic    r_item_valid;
    logic    r_res_valid;
    logic    res_ready;
    logic    s_ready;

    srca_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // result register frees when empty or when the sink takes the word
    assign res_ready = !r_res_valid || i_m_tready;
    // input register frees when empty or when its word moves on
    assign s_ready   = !r_item_valid || res_ready;
    assign o_s_tready = s_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (s_ready) begin
            r_item_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_tvalid) begin
            r_item.pos_x   <= i_s_tdata[15:0];
            r_item.pos_y   <= i_s_tdata[31:16];
            r_item.no_clip <= i_s_tuser;
        end
    end

    // clip and address arithmetic, one pass
    srca_clip #(
        .ROW_BYTES (ROW_BYTES)
    ) u_clip (
        .i_cfg  (cfg),
        .i_item (r_item),
        .o_res  (clip_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_ready) begin
            r_res_valid <= r_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && r_item_valid) begin
            r_res <= clip_res;
        end
    end

    assign o_m_tvalid = r_res_valid;
    assign o_m_tdata  = {r_res.bytes_out, r_res.rows_out, r_res.source_start,
                         r_res.vram_offset};
    assign o_m_tuser  = r_res.visible;

`ifndef SYNTHESIS
    // a clipped-away sprite carries all-zero fields
    a_invisible_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_res.visible) |-> (o_m_tdata == 48'd0))
        else $error("invisible result with non-zero fields");

    // back-pressure at the input only with both the input and the result register full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_ready |-> (r_item_valid && r_res_valid))
        else $error("input stalled with a free stage");

    // an accepted word occupies the input register next cycle
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && s_ready) |=> r_item_valid)
        else $error("accepted word lost");

    // a word that moves on occupies the result register next cycle
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_valid && res_ready) |=> r_res_valid)
        else $error("clipped word lost");
`endif

endmodule
